// File: rtl/mpc_pkg.sv
package mpc_pkg;

    // Field and register widths fixed by the interface
    localparam int unsigned DUR_W     = 27;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned WEIGHT_W  = 9;
    localparam int unsigned CFG_W     = 27;
    localparam int unsigned CFG_IDX_W = 3;

    // Default parameter values
    localparam int unsigned DEF_SAMPLE_BITS = 12;
    localparam int unsigned DEF_TIME_BITS   = 32;

    // Moisture mapping: raw 2700 is bone dry, raw 1100 is soaked.
    // The 1600-count span onto 100 percent is exactly a divide by 16.
    localparam int unsigned DRY_RAW      = 2700;
    localparam int unsigned PCT_SHIFT    = 4;
    localparam int unsigned FULL_PERCENT = 100;
    localparam int unsigned WEIGHT_FULL  = 256;

    // Register reset values
    localparam logic [CFG_W-1:0]    RST_PUMP_TIME  = CFG_W'(7000);
    localparam logic [CFG_W-1:0]    RST_CHECK_INT  = CFG_W'(60000 * 20);
    localparam logic [PCT_W-1:0]    RST_DRY_THR    = PCT_W'(40);
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT     = WEIGHT_W'(26);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NIGHT     = 3'd0,
        CFG_AUTO      = 3'd1,
        CFG_PUMP_TIME = 3'd2,
        CFG_CHECK_INT = 3'd3,
        CFG_DRY_THR   = 3'd4,
        CFG_WEIGHT    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_STOP    = 2'd0,
        EV_START   = 2'd1,
        EV_MISSING = 2'd2
    } t_event;

    typedef enum logic {
        PH_MAIN  = 1'b0,
        PH_CHECK = 1'b1
    } t_phase;

    typedef enum logic {
        CMD_TICK    = 1'b0,
        CMD_REQUEST = 1'b1
    } t_cmd;

endpackage

// File: rtl/mpc_sense.sv
module mpc_sense #(
    parameter int unsigned SAMPLE_BITS = mpc_pkg::DEF_SAMPLE_BITS
) (
    input  logic [mpc_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic [SAMPLE_BITS+7:0]       i_level,
    output logic [SAMPLE_BITS+7:0]       o_level,
    output logic [mpc_pkg::PCT_W-1:0]    o_percent
);
    import mpc_pkg::*;

    localparam int unsigned LVL_W = SAMPLE_BITS + 8;
    localparam int unsigned NEW_W = LVL_W + 1;
    localparam int unsigned OLD_W = LVL_W + WEIGHT_W;
    localparam int unsigned D_W   = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;

    logic [WEIGHT_W-1:0]    w;
    logic [WEIGHT_W-1:0]    wc;
    logic [NEW_W-1:0]       p_new;
    logic [OLD_W-1:0]       p_old;
    logic [NEW_W-1:0]       sum;
    logic [D_W-1:0]         xe;
    logic [D_W-1:0]         d;
    logic [D_W-1:0]         q;

    // Q8 exponential average; weight times sample is already in Q8, so the new-sample term needs no shift
    assign w     = (i_weight > WEIGHT_W'(WEIGHT_FULL)) ? WEIGHT_W'(WEIGHT_FULL) : i_weight;
    assign wc    = WEIGHT_W'(WEIGHT_FULL) - w;
    assign p_new = NEW_W'(w) * NEW_W'(i_sample);
    assign p_old = OLD_W'(wc) * OLD_W'(i_level);
    assign sum   = p_new + NEW_W'(p_old >> 8);
    assign o_level = sum[LVL_W-1:0];

    // Map the integer part onto percent, truncate, clamp
    assign xe = D_W'(o_level[LVL_W-1:8]);
    assign d  = D_W'(DRY_RAW) - xe;
    assign q  = d >> PCT_SHIFT;

    always_comb begin
        if (xe >= D_W'(DRY_RAW)) begin
            o_percent = '0;
        end else if (q > D_W'(FULL_PERCENT)) begin
            o_percent = PCT_W'(FULL_PERCENT);
        end else begin
            o_percent = q[PCT_W-1:0];
        end
    end

endmodule

// File: rtl/moisture_pump_controller_top.sv
// An accepted request beat or plain tick is registered in the input slot, its result beat
//   in the result slots at commit; a tick that runs a moisture check goes through a main
//   phase (sensor read), then a check phase (decision). Throughput: one item per cycle
//   outside checks; the output pair of result slots must drain before the next item commits.
// Reset (i_rst_n low, synchronous): registers take their default values, clock,
//   deadlines, pump and smoothed level clear, and both stream sides go empty.
module moisture_pump_controller_top #(
    parameter int unsigned SAMPLE_BITS = mpc_pkg::DEF_SAMPLE_BITS,
    parameter int unsigned TIME_BITS   = mpc_pkg::DEF_TIME_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [mpc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [mpc_pkg::CFG_W-1:0]             i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, low bit up: moisture_sample, water_missing, pump_duration
    input  logic [((SAMPLE_BITS+28+7)/8)*8-1:0]   s_axis_tdata,
    // tuser: command
    input  logic                                  s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata, low bit up: moisture_percent, pump_running
    output logic [7:0]                            m_axis_tdata,
    // tuser: event_res
    output logic [1:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import mpc_pkg::*;

    localparam int unsigned LVL_W = SAMPLE_BITS + 8;
    localparam int unsigned SUM_W = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;

    // Saturating time add: any carry past the clock width pins at all ones
    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [DUR_W-1:0]     b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s[SUM_W-1:TIME_BITS] != '0) begin
            return '1;
        end
        return s[TIME_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic                r_night;
    logic                r_auto;
    logic [DUR_W-1:0]    r_pump_time;
    logic [DUR_W-1:0]    r_check_int;
    logic [PCT_W-1:0]    r_dry_thr;
    logic [WEIGHT_W-1:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_night     <= 1'b0;
            r_auto      <= 1'b1;
            r_pump_time <= RST_PUMP_TIME;
            r_check_int <= RST_CHECK_INT;
            r_dry_thr   <= RST_DRY_THR;
            r_weight    <= RST_WEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NIGHT:     r_night     <= i_cfg_data[0];
                CFG_AUTO:      r_auto      <= i_cfg_data[0];
                CFG_PUMP_TIME: r_pump_time <= i_cfg_data[DUR_W-1:0];
                CFG_CHECK_INT: r_check_int <= i_cfg_data[DUR_W-1:0];
                CFG_DRY_THR:   r_dry_thr   <= i_cfg_data[PCT_W-1:0];
                CFG_WEIGHT:    r_weight    <= i_cfg_data[WEIGHT_W-1:0];
                default: ; // ignore writes past the register list
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input register: holds one beat while the sequencer works on it
    // ---------------------------------------------------------------------
    logic                   r_in_valid;
    t_cmd                   r_in_cmd;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic                   r_in_missing;
    logic [DUR_W-1:0]       r_in_dur;
    logic                   done;

    // Take a new beat whenever the slot is empty or its item retires now
    assign s_axis_tready = !r_in_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd     <= t_cmd'(s_axis_tuser);
            r_in_sample  <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_missing <= s_axis_tdata[SAMPLE_BITS];
            r_in_dur     <= s_axis_tdata[SAMPLE_BITS+DUR_W:SAMPLE_BITS+1];
        end
    end

    // ---------------------------------------------------------------------
    // Controller state
    // ---------------------------------------------------------------------
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_pump_dl;
    logic [TIME_BITS-1:0] r_check_dl;
    logic                 r_pump_on;
    logic [LVL_W-1:0]     r_level;
    logic [PCT_W-1:0]     r_moist;
    t_phase               r_phase;
    logic                 r_stopped;   // the main phase already stopped the pump

    // Sensor path: one read per cycle from the current smoothed level
    logic [LVL_W-1:0] sense_level;
    logic [PCT_W-1:0] sense_pct;

    mpc_sense #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_sense (
        .i_weight  (r_weight),
        .i_sample  (r_in_sample),
        .i_level   (r_level),
        .o_level   (sense_level),
        .o_percent (sense_pct)
    );

    // ---------------------------------------------------------------------
    // Result slots: slot 0 is on the bus, slot 1 waits behind it
    // ---------------------------------------------------------------------
    logic [1:0]       r_oc;
    t_event           r_out_ev   [2];
    logic [PCT_W-1:0] r_out_pct  [2];
    logic             r_out_run  [2];
    logic             r_out_last [2];

    logic pop;
    logic can_push;
    logic go;

    assign pop      = (r_oc != 2'd0) && m_axis_tready;
    // Commit an item only into slots that are empty after this cycle's beat
    assign can_push = (r_oc == 2'd0) || ((r_oc == 2'd1) && pop);
    assign go       = r_in_valid && can_push;

    // ---------------------------------------------------------------------
    // Per-item decision logic
    // ---------------------------------------------------------------------
    logic [TIME_BITS-1:0] now_inc;
    logic                 stop;
    logic                 chk;
    logic                 dry;
    logic                 start_ok;
    t_event               start_ev;
    logic                 start_run;

    logic [TIME_BITS-1:0] n_now;
    logic [TIME_BITS-1:0] n_pump_dl;
    logic [TIME_BITS-1:0] n_check_dl;
    logic                 n_pump_on;
    logic [LVL_W-1:0]     n_level;
    logic [PCT_W-1:0]     n_moist;
    t_phase               n_phase;
    logic                 n_stopped;

    logic [1:0]           npush;
    t_event               res_ev   [2];
    logic [PCT_W-1:0]     res_pct  [2];
    logic                 res_run  [2];
    logic                 res_last [2];

    assign now_inc  = sat_add(r_now, DUR_W'(1));
    assign stop     = r_pump_on && (r_pump_dl < now_inc);
    assign chk      = !r_night && r_auto && (now_inc > r_check_dl);
    assign dry      = sense_pct < r_dry_thr;
    assign start_ok = !r_in_missing;
    assign start_ev = start_ok ? EV_START : EV_MISSING;
    // a missing-water report leaves the pump as it was
    assign start_run = start_ok ? 1'b1 : r_pump_on;

    // Retire the item unless a tick still owes its check phase
    assign done = go && ((r_phase == PH_CHECK) || (r_in_cmd == CMD_REQUEST) || !chk);

    // Phase sequencing: a checking tick moves from the main phase to the check phase, and back on commit
    always_comb begin
        n_phase = r_phase;
        if (go) begin
            unique case (r_phase)
                PH_MAIN: begin
                    if ((r_in_cmd == CMD_TICK) && chk) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_MAIN;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_now      = r_now;
        n_pump_dl  = r_pump_dl;
        n_check_dl = r_check_dl;
        n_pump_on  = r_pump_on;
        n_level    = r_level;
        n_moist    = r_moist;
        n_stopped  = r_stopped;
        npush      = 2'd0;
        for (int k = 0; k < 2; k++) begin
            res_ev[k]   = EV_STOP;
            res_pct[k]  = r_moist;
            res_run[k]  = 1'b0;
            res_last[k] = 1'b0;
        end

        if (go) begin
            unique case (r_phase)
                PH_MAIN: begin
                    if (r_in_cmd == CMD_REQUEST) begin
                        // manual request: restart the deadline from now
                        if (start_ok) begin
                            n_pump_on = 1'b1;
                            n_pump_dl = sat_add(r_now, r_in_dur);
                        end
                        npush       = 2'd1;
                        res_ev[0]   = start_ev;
                        res_run[0]  = start_run;
                        res_last[0] = 1'b1;
                    end else begin
                        n_now = now_inc;
                        if (stop) begin
                            n_pump_on = 1'b0;
                            n_level   = sense_level;
                            n_moist   = sense_pct;
                        end
                        if (chk) begin
                            // hold the stop result until the check decides
                            n_check_dl = sat_add(now_inc, r_check_int);
                            n_stopped  = stop;
                        end else if (stop) begin
                            npush       = 2'd1;
                            res_ev[0]   = EV_STOP;
                            res_pct[0]  = sense_pct;
                            res_run[0]  = 1'b0;
                            res_last[0] = 1'b1;
                        end
                    end
                end
                PH_CHECK: begin
                    // second sensor read of the same sample, then decide
                    n_level = sense_level;
                    n_moist = sense_pct;
                    if (dry && start_ok) begin
                        n_pump_on = 1'b1;
                        n_pump_dl = sat_add(r_now, r_pump_time);
                    end
                    if (r_stopped) begin
                        res_ev[0]   = EV_STOP;
                        res_pct[0]  = r_moist;
                        res_run[0]  = 1'b0;
                        res_last[0] = !dry;
                        res_ev[1]   = start_ev;
                        res_pct[1]  = sense_pct;
                        res_run[1]  = start_run;
                        res_last[1] = 1'b1;
                        npush       = dry ? 2'd2 : 2'd1;
                    end else begin
                        res_ev[0]   = start_ev;
                        res_pct[0]  = sense_pct;
                        res_run[0]  = start_run;
                        res_last[0] = 1'b1;
                        npush       = dry ? 2'd1 : 2'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_pump_dl  <= '0;
            r_check_dl <= '0;
            r_pump_on  <= 1'b0;
            r_level    <= '0;
            r_moist    <= '0;
            r_phase    <= PH_MAIN;
            r_stopped  <= 1'b0;
        end else begin
            r_now      <= n_now;
            r_pump_dl  <= n_pump_dl;
            r_check_dl <= n_check_dl;
            r_pump_on  <= n_pump_on;
            r_level    <= n_level;
            r_moist    <= n_moist;
            r_phase    <= n_phase;
            r_stopped  <= n_stopped;
        end
    end

    // Slot count: a commit refills from empty, otherwise advance on a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc <= 2'd0;
        end else if (go) begin
            r_oc <= npush;
        end else if (pop) begin
            r_oc <= r_oc - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            for (int k = 0; k < 2; k++) begin
                r_out_ev[k]   <= res_ev[k];
                r_out_pct[k]  <= res_pct[k];
                r_out_run[k]  <= res_run[k];
                r_out_last[k] <= res_last[k];
            end
        end else if (pop) begin
            r_out_ev[0]   <= r_out_ev[1];
            r_out_pct[0]  <= r_out_pct[1];
            r_out_run[0]  <= r_out_run[1];
            r_out_last[0] <= r_out_last[1];
        end
    end

    assign m_axis_tvalid = (r_oc != 2'd0);
    assign m_axis_tdata  = {r_out_run[0], r_out_pct[0]};
    assign m_axis_tuser  = r_out_ev[0];
    assign m_axis_tlast  = r_out_last[0];

endmodule
